/* src/u8u16_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared widths, constants, types and the lead byte decode for the UTF-8 to
// UTF-16 stream decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned UnitW = 16;
  localparam int unsigned CpW   = 31;
  localparam int unsigned LenW  = 3;

  localparam logic [UnitW-1:0] RepReset  = 16'h002E;  // '.'
  localparam logic [UnitW-1:0] HiSurBase = 16'hD800;
  localparam logic [UnitW-1:0] LoSurBase = 16'hDC00;
  localparam logic [CpW-1:0]   CpMax     = 31'h0010FFFF;
  localparam logic [CpW-1:0]   CpBom     = 31'h0000FEFF;
  localparam logic [CpW-1:0]   CpPlane1  = 31'h00010000;
  localparam logic [CpW-1:0]   SurMask   = 31'h7FFFF800;
  localparam logic [CpW-1:0]   SurBase   = 31'h0000D800;
  localparam logic [CpW-1:0]   Min2      = 31'h00000080;
  localparam logic [CpW-1:0]   Min3      = 31'h00000800;
  localparam logic [CpW-1:0]   Min4      = 31'h00010000;

  // What one lead byte does when no sequence is pending.
  typedef struct packed {
    logic            emit;     // emits a unit (ASCII or illegal lead)
    logic            illegal;  // unit is the replacement
    logic [LenW-1:0] len;      // sequence length, 0 when emitting
    logic [CpW-1:0]  pcp;      // payload bits from the lead byte
  } u8u16_lead_t;

  // Units produced by one word.
  typedef struct packed {
    logic [1:0]       cnt;
    logic [UnitW-1:0] unit0;
    logic [UnitW-1:0] unit1;
  } u8u16_res_t;

  function automatic u8u16_lead_t lead_decode(input logic [ByteW-1:0] b);
    u8u16_lead_t r;
    r = '0;
    if (!b[7]) begin
      r.emit = 1'b1;
    end else if (b[7:5] == 3'b110) begin
      r.len = 3'd2;
      r.pcp = CpW'({b[4:0], 6'b0});
    end else if (b[7:4] == 4'b1110) begin
      r.len = 3'd3;
      r.pcp = CpW'({b[3:0], 12'b0});
    end else if (b[7:3] == 5'b11110) begin
      r.len = 3'd4;
      r.pcp = CpW'({b[2:0], 18'b0});
    end else if (b[7:2] == 6'b111110) begin
      r.len = 3'd5;
      r.pcp = CpW'({b[1:0], 24'b0});
    end else if (b[7:1] == 7'b1111110) begin
      r.len = 3'd6;
      r.pcp = {b[0], 30'b0};
    end else begin
      r.emit    = 1'b1;
      r.illegal = 1'b1;
    end
    return r;
  endfunction

endpackage

/* src/u8u16_byte_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_byte_if
// Valid/ready channel carrying one UTF-8 byte and a start-of-string flag.
// ----------------------------------------------------------------------------
interface u8u16_byte_if;
  import u8u16_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] byte_value;
  logic             start_of_string;

  modport source (output valid, output byte_value, output start_of_string, input ready);
  modport sink   (input valid, input byte_value, input start_of_string, output ready);
endinterface

/* src/u8u16_unit_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_unit_if
// Valid/ready channel carrying one UTF-16 code unit and its end-of-run flag.
// ----------------------------------------------------------------------------
interface u8u16_unit_if;
  import u8u16_pkg::*;

  logic             valid;
  logic             ready;
  logic [UnitW-1:0] code_unit;
  logic             last_of_run;

  modport source (output valid, output code_unit, output last_of_run, input ready);
  modport sink   (input valid, input code_unit, input last_of_run, output ready);
endinterface

/* src/utf8_to_utf16_stream_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_stream_decoder
// UTF-8 byte stream in, UTF-16 code units out, with replacement of
// malformed input and byte order mark removal.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   : one word per UTF-8 byte; start_of_string clears the decoder
//            (and the "output begun" flag) before that byte is decoded,
//            silently dropping any unfinished sequence.
//   out_o  : one word per UTF-16 unit; last_of_run marks the final unit a
//            byte produced. A byte makes zero, one or two units.
//   cfg_we_i/cfg_wdata_i : replacement unit, reset to '.', write only
//            while the block is idle.
// Path: a byte is captured in an input stage, decoded in one pass of
//   logic and its units land in a two-entry result register, from which
//   the head unit is presented on out_o.
// Throughput: one byte per cycle while out_o.ready is high; the output
//   drains one unit per cycle, so a byte that yields two units (surrogate pair,
//   or replacement plus a new unit) holds the input stage until the second unit is popped.
// Stall: when out_o.ready is low the result register holds, the input
//   stage keeps one byte, and in_i.ready drops until room frees. Bytes
//   yielding no unit pass on without needing room.
// Reset: asynchronous, clears the decoder state, both stages and sets the
//   replacement unit back to '.'.
// ----------------------------------------------------------------------------
module utf8_to_utf16_stream_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  u8u16_byte_if.sink                  in_i,
  u8u16_unit_if.source                out_o,
  input  logic                        cfg_we_i,
  input  logic [u8u16_pkg::UnitW-1:0] cfg_wdata_i
);
  import u8u16_pkg::*;

  logic [UnitW-1:0] rep_q;

  // input stage
  logic             stg_vld_q;
  logic [ByteW-1:0] stg_byte_q;
  logic             stg_sos_q;

  // result register: up to two units, head at index 0
  logic [1:0]       cnt_q, cnt_d;
  logic [UnitW-1:0] unit_q [2];
  logic [UnitW-1:0] unit_d [2];
  logic [1:0]       last_q, last_d;

  u8u16_res_t res;
  logic       in_acc, out_pop, room, advance, load;

  assign out_o.valid       = (cnt_q != 2'd0);
  assign out_o.code_unit   = unit_q[0];
  assign out_o.last_of_run = last_q[0];
  assign out_pop           = out_o.valid && out_o.ready;

  // room once the buffer is empty after this edge; no-unit bytes need none
  assign room    = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_pop);
  assign advance = stg_vld_q && (room || res.cnt == 2'd0);
  assign load    = advance && (res.cnt != 2'd0);

  assign in_i.ready = !stg_vld_q || advance;
  assign in_acc     = in_i.valid && in_i.ready;

  u8u16_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (stg_byte_q),
    .sos_i  (stg_sos_q),
    .rep_i  (rep_q),
    .res_o  (res)
  );

  always_comb begin
    cnt_d  = cnt_q;
    unit_d = unit_q;
    last_d = last_q;
    if (load) begin
      cnt_d     = res.cnt;
      unit_d[0] = res.unit0;
      unit_d[1] = res.unit1;
      last_d    = {1'b1, res.cnt == 2'd1};
    end else if (out_pop) begin
      cnt_d     = cnt_q - 2'd1;
      unit_d[0] = unit_q[1];
      last_d[0] = last_q[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_q     <= RepReset;
      stg_vld_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        rep_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        stg_vld_q <= 1'b1;
      end else if (advance) begin
        stg_vld_q <= 1'b0;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      stg_byte_q <= in_i.byte_value;
      stg_sos_q  <= in_i.start_of_string;
    end
    unit_q <= unit_d;
    last_q <= last_d;
  end

  // buffer never holds more than a pair
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result count out of range");

  // with two units pending the head is never the end of a run
  a_pair_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !last_q[0] && last_q[1])
    else $error("pair end flags wrong");

  // a byte blocked in the input stage stays put
  a_stage_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_vld_q && !advance |=> stg_vld_q && $stable(stg_byte_q) && $stable(stg_sos_q))
    else $error("input stage lost a blocked byte");

  // units only load into an emptying buffer
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> cnt_q == 2'd0 || (cnt_q == 2'd1 && out_pop))
    else $error("result register overwritten");

endmodule

/* src/u8u16_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_decode
// Decoder state and the single-pass decode of one byte into 0..2 units.
// State commits when step_i is high.
// ----------------------------------------------------------------------------
module u8u16_decode (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [u8u16_pkg::ByteW-1:0] byte_i,
  input  logic                       sos_i,
  input  logic [u8u16_pkg::UnitW-1:0] rep_i,
  output u8u16_pkg::u8u16_res_t      res_o
);
  import u8u16_pkg::*;

  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] left_q, left_d;
  logic [CpW-1:0]  pcp_q, pcp_d;
  logic            begun_q, begun_d;

  logic [LenW-1:0] s_len, s_left, left_m1;
  logic [CpW-1:0]  s_pcp, cont_bits, cp;
  logic            s_begun, bad;
  logic [CpW-1:0]  v;
  u8u16_lead_t     ld;
  logic [UnitW-1:0] lead_unit;

  assign s_len   = sos_i ? '0 : len_q;
  assign s_left  = sos_i ? '0 : left_q;
  assign s_pcp   = sos_i ? '0 : pcp_q;
  assign s_begun = sos_i ? 1'b0 : begun_q;

  assign ld        = lead_decode(byte_i);
  assign lead_unit = ld.illegal ? rep_i : {{(UnitW-ByteW){1'b0}}, byte_i};

  assign left_m1 = (s_left == '0) ? '0 : s_left - 3'd1;

  always_comb begin
    case (left_m1)
      3'd0:    cont_bits = CpW'(byte_i[5:0]);
      3'd1:    cont_bits = CpW'({byte_i[5:0], 6'b0});
      3'd2:    cont_bits = CpW'({byte_i[5:0], 12'b0});
      3'd3:    cont_bits = CpW'({byte_i[5:0], 18'b0});
      3'd4:    cont_bits = CpW'({byte_i[5:0], 24'b0});
      3'd5:    cont_bits = {byte_i[0], 30'b0};
      default: cont_bits = '0;
    endcase
  end

  assign cp  = s_pcp | cont_bits;
  assign v   = cp - CpPlane1;
  assign bad = (s_len == 3'd2 && cp < Min2) || (s_len == 3'd3 && cp < Min3)
            || (s_len == 3'd4 && cp < Min4) || (s_len > 3'd4)
            || ((cp & SurMask) == SurBase) || (cp > CpMax);

  always_comb begin
    res_o   = '0;
    len_d   = s_len;
    left_d  = s_left;
    pcp_d   = s_pcp;
    if (s_len == '0) begin
      if (ld.emit) begin
        res_o.cnt   = 2'd1;
        res_o.unit0 = lead_unit;
      end else begin
        len_d  = ld.len;
        left_d = ld.len - 3'd1;
        pcp_d  = ld.pcp;
      end
    end else if (byte_i[7:6] == 2'b10) begin
      pcp_d  = cp;
      left_d = left_m1;
      if (left_m1 == '0) begin
        len_d = '0;
        if (bad) begin
          res_o.cnt   = 2'd1;
          res_o.unit0 = rep_i;
        end else if (cp > CpW'(32'hFFFF)) begin
          res_o.cnt   = 2'd2;
          res_o.unit0 = HiSurBase | UnitW'(v[19:10]);
          res_o.unit1 = LoSurBase | UnitW'(v[9:0]);
        end else if (cp != CpBom || s_begun) begin
          res_o.cnt   = 2'd1;
          res_o.unit0 = cp[UnitW-1:0];
        end
      end
    end else begin
      // broken sequence: replacement, then the byte starts over as a lead
      res_o.unit0 = rep_i;
      if (ld.emit) begin
        res_o.cnt   = 2'd2;
        res_o.unit1 = lead_unit;
        len_d       = '0;
        left_d      = '0;
      end else begin
        res_o.cnt = 2'd1;
        len_d     = ld.len;
        left_d    = ld.len - 3'd1;
        pcp_d     = ld.pcp;
      end
    end
    begun_d = s_begun | (res_o.cnt != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      left_q  <= '0;
      pcp_q   <= '0;
      begun_q <= 1'b0;
    end else if (step_i) begin
      len_q   <= len_d;
      left_q  <= left_d;
      pcp_q   <= pcp_d;
      begun_q <= begun_d;
    end
  end

endmodule
